/* hdl/permutation_order_crossover_core_defines.svh */
// ----------------------------------------------------------------------------
// permutation order crossover core assertion macros
// shared property forms for the port checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_ORDER_CROSSOVER_CORE_DEFINES_SVH
`define PERMUTATION_ORDER_CROSSOVER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define POCX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pocx same-cycle check failed");

// antecedent implies consequent in the next cycle
`define POCX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pocx next-cycle check failed");

`endif

/* hdl/pocx_pkg.sv */
// ----------------------------------------------------------------------------
// pocx_pkg
// shared types and constants of the order crossover core
// ----------------------------------------------------------------------------
`default_nettype none

package pocx_pkg;

    localparam int GENE_W     = 6;
    localparam int GENE_SPACE = 64;
    localparam int CUT_W      = 7;

    typedef logic [GENE_W-1:0] t_gene;
    typedef logic [CUT_W-1:0]  t_cut;

    // per-cycle command from the sequencer to one child builder
    typedef struct packed {
        logic  clear;
        logic  prefix_wr;
        logic  append_req;
        t_gene prefix_gene;
        t_gene append_gene;
    } t_child_ctrl;

endpackage

`default_nettype wire

/* hdl/pocx_if.sv */
// ----------------------------------------------------------------------------
// pocx channel interfaces
// valid/ready channels for parent gene pairs and child gene pairs
// ----------------------------------------------------------------------------
`default_nettype none

interface pocx_in_if
    import pocx_pkg::*;
();
    logic  valid;
    logic  ready;
    t_gene first_parent_gene;
    t_gene second_parent_gene;
    t_cut  cut_point;
    logic  last_gene;

    modport source (
        output valid, first_parent_gene, second_parent_gene, cut_point, last_gene,
        input  ready
    );
    modport sink (
        input  valid, first_parent_gene, second_parent_gene, cut_point, last_gene,
        output ready
    );
endinterface

interface pocx_out_if
    import pocx_pkg::*;
();
    logic  valid;
    logic  ready;
    t_gene first_child_gene;
    logic  first_child_valid;
    t_gene second_child_gene;
    logic  second_child_valid;
    logic  last_child_gene;

    modport source (
        output valid, first_child_gene, first_child_valid, second_child_gene,
               second_child_valid, last_child_gene,
        input  ready
    );
    modport sink (
        input  valid, first_child_gene, first_child_valid, second_child_gene,
               second_child_valid, last_child_gene,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/pocx_child.sv */
// ----------------------------------------------------------------------------
// pocx_child
// builds one child: seen bits, fill length and gene memory
// ----------------------------------------------------------------------------
`default_nettype none

module pocx_child
    import pocx_pkg::*;
#(
    parameter int MAX_GENES = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_child_ctrl                        i_ctrl,
    input  wire logic [$clog2(MAX_GENES+1)-1:0]     i_limit,
    input  wire logic [$clog2(MAX_GENES)-1:0]       i_rd_addr,
    output logic [$clog2(MAX_GENES+1)-1:0]          o_len,
    output t_gene                                   o_rd_gene
);

    localparam int IDX_W = $clog2(MAX_GENES);
    localparam int CNT_W = $clog2(MAX_GENES + 1);

    logic [GENE_SPACE-1:0] r_seen;
    logic [CNT_W-1:0]      r_len;
    t_gene                 r_mem [MAX_GENES];
    t_gene                 r_rd_gene;

    logic  seen_hit;
    logic  room;
    logic  wr_en;
    t_gene wr_gene;

    assign seen_hit = r_seen[i_ctrl.append_gene];
    assign room     = r_len < i_limit;
    assign wr_en    = i_ctrl.prefix_wr | (i_ctrl.append_req & ~seen_hit & room);
    assign wr_gene  = i_ctrl.prefix_wr ? i_ctrl.prefix_gene : i_ctrl.append_gene;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_len  <= '0;
        end else if (i_ctrl.clear) begin
            r_seen <= '0;
            r_len  <= '0;
        end else if (i_ctrl.prefix_wr) begin
            r_seen[i_ctrl.prefix_gene] <= 1'b1;
            r_len                      <= r_len + CNT_W'(1);
        end else if (i_ctrl.append_req && !seen_hit) begin
            // the gene counts as held even when the child is already full
            r_seen[i_ctrl.append_gene] <= 1'b1;
            if (room) begin
                r_len <= r_len + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_len[IDX_W-1:0]] <= wr_gene;
        end
        r_rd_gene <= r_mem[i_rd_addr];
    end

    assign o_len     = r_len;
    assign o_rd_gene = r_rd_gene;

endmodule

`default_nettype wire

/* hdl/permutation_order_crossover_core.sv */
// ----------------------------------------------------------------------------
// permutation_order_crossover_core
// one-point order crossover of two parent permutations into two children
// sequence: parent pairs are loaded while the input is ready; after the last pair
//   the sequencer runs the prefix copy up to the cut, then the merge scan
// emit: each child pair goes through a child memory read followed by the output
//   register, where a stall holds it; the input is held off until done
// reset: synchronous active-low i_rst_n clears the sequencer, counters and seen
//   bits; gene memories are not cleared and are only read where written
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_order_crossover_core
    import pocx_pkg::*;
#(
    parameter int MAX_GENES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pocx_in_if.sink    i_in,
    pocx_out_if.source o_out
);

    localparam int IDX_W = $clog2(MAX_GENES);
    localparam int CNT_W = $clog2(MAX_GENES + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREFIX,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;       // positions loaded for the current pair
    t_cut             r_cut;       // cut point taken with the first transfer
    logic [CNT_W-1:0] r_n;         // loaded length of the finished pair
    logic [CNT_W-1:0] r_cut_sat;   // cut saturated to the loaded length
    logic [CNT_W-1:0] r_idx;       // scan / emit position
    logic             r_rd_valid;  // parent read data arrives this cycle
    logic             r_rd_prefix; // ... and belongs to the prefix pass
    logic             r_out_valid;
    logic             r_v1;
    logic             r_v2;
    logic             r_last;

    // parent gene memories
    t_gene r_p1_mem [MAX_GENES];
    t_gene r_p2_mem [MAX_GENES];
    t_gene r_p1_q;
    t_gene r_p2_q;

    logic             in_xfer;
    logic             out_xfer;
    logic             has_room;
    t_cut             n_held_cut;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_cut_sat;

    t_child_ctrl      c1_ctrl;
    t_child_ctrl      c2_ctrl;
    logic [CNT_W-1:0] c1_len;
    logic [CNT_W-1:0] c2_len;
    t_gene            c1_q;
    t_gene            c2_q;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_xfer    = i_in.valid & i_in.ready;
    assign out_xfer   = r_out_valid & o_out.ready;

    // items past the capacity are dropped, but their last flag still counts
    assign has_room   = r_cnt < CNT_W'(MAX_GENES);
    assign n_held_cut = (r_cnt == '0) ? i_in.cut_point : r_cut;
    assign n_count    = has_room ? r_cnt + CNT_W'(1) : r_cnt;
    assign n_cut_sat  = (n_held_cut < CUT_W'(n_count)) ? CNT_W'(n_held_cut) : n_count;

    always_ff @(posedge i_clk) begin
        if (in_xfer && has_room) begin
            r_p1_mem[r_cnt[IDX_W-1:0]] <= i_in.first_parent_gene;
            r_p2_mem[r_cnt[IDX_W-1:0]] <= i_in.second_parent_gene;
        end
        r_p1_q <= r_p1_mem[r_idx[IDX_W-1:0]];
        r_p2_q <= r_p2_mem[r_idx[IDX_W-1:0]];
    end

    // sequencer: load, prefix copy, merge scan, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_cut       <= '0;
            r_n         <= '0;
            r_cut_sat   <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_prefix <= 1'b0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (i_in.last_gene) begin
                            r_n       <= n_count;
                            r_cut_sat <= n_cut_sat;
                            r_cnt     <= '0;
                            r_cut     <= '0;
                            r_idx     <= '0;
                            r_state   <= S_PREFIX;
                        end else begin
                            r_cut <= n_held_cut;
                            r_cnt <= n_count;
                        end
                    end
                end
                S_PREFIX: begin
                    // each child copies its own parent up to the cut
                    if (r_idx < r_cut_sat) begin
                        r_rd_valid  <= 1'b1;
                        r_rd_prefix <= 1'b1;
                        r_idx       <= r_idx + CNT_W'(1);
                    end else begin
                        r_rd_valid <= 1'b0;
                        r_idx      <= '0;
                        r_state    <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    // scan the other parent from the start, append what is new
                    if (r_idx < r_n) begin
                        r_rd_valid  <= 1'b1;
                        r_rd_prefix <= 1'b0;
                        r_idx       <= r_idx + CNT_W'(1);
                    end else begin
                        // the last read is absorbed by the children at this edge
                        r_rd_valid <= 1'b0;
                        r_idx      <= '0;
                        r_state    <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    // child memories present r_idx in the next cycle
                    r_v1        <= r_idx < c1_len;
                    r_v2        <= r_idx < c2_len;
                    r_last      <= (r_idx + CNT_W'(1)) == r_n;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // child commands: the first child takes its prefix from the first parent
    // and merges the second; the second child the other way around
    always_comb begin
        c1_ctrl.clear       = in_xfer & i_in.last_gene;
        c1_ctrl.prefix_wr   = r_rd_valid & r_rd_prefix;
        c1_ctrl.append_req  = r_rd_valid & ~r_rd_prefix;
        c1_ctrl.prefix_gene = r_p1_q;
        c1_ctrl.append_gene = r_p2_q;

        c2_ctrl.clear       = in_xfer & i_in.last_gene;
        c2_ctrl.prefix_wr   = r_rd_valid & r_rd_prefix;
        c2_ctrl.append_req  = r_rd_valid & ~r_rd_prefix;
        c2_ctrl.prefix_gene = r_p2_q;
        c2_ctrl.append_gene = r_p1_q;
    end

    pocx_child #(
        .MAX_GENES (MAX_GENES)
    ) u_child1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (c1_ctrl),
        .i_limit   (r_n),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_len     (c1_len),
        .o_rd_gene (c1_q)
    );

    pocx_child #(
        .MAX_GENES (MAX_GENES)
    ) u_child2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (c2_ctrl),
        .i_limit   (r_n),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_len     (c2_len),
        .o_rd_gene (c2_q)
    );

    // result transfer; positions past a short child read as gene zero
    assign o_out.valid              = r_out_valid;
    assign o_out.first_child_gene   = r_v1 ? c1_q : '0;
    assign o_out.first_child_valid  = r_v1;
    assign o_out.second_child_gene  = r_v2 ? c2_q : '0;
    assign o_out.second_child_valid = r_v2;
    assign o_out.last_child_gene    = r_last;

endmodule

`default_nettype wire

/* hdl/pocx_checker.sv */
// ----------------------------------------------------------------------------
// pocx_checker
// port-level checks of the order crossover core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "permutation_order_crossover_core_defines.svh"

module pocx_checker
    import pocx_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire logic  i_in_last,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_gene i_out_gene1,
    input wire t_gene i_out_gene2,
    input wire logic  i_out_last
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid & i_in_ready;
    assign out_xfer = i_out_valid & i_out_ready;

    // no loading while results are pending
    `POCX_ASSERT_SAME(a_no_overlap, i_out_valid, !i_in_ready)
    // the last parent pair starts the compute phase
    `POCX_ASSERT_NEXT(a_last_blocks_input, in_xfer && i_in_last, !i_in_ready)
    // each result needs a fresh child memory read
    `POCX_ASSERT_NEXT(a_gap_after_result, out_xfer, !i_out_valid)
    // a stalled result holds
    `POCX_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_gene1) && $stable(i_out_gene2) && $stable(i_out_last))

endmodule

bind permutation_order_crossover_core pocx_checker u_pocx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_gene),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_gene1 (o_out.first_child_gene),
    .i_out_gene2 (o_out.second_child_gene),
    .i_out_last  (o_out.last_child_gene)
);

`default_nettype wire
